// ===== rtl/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the k-means pass engine.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int BandInputs = 7;

  localparam logic [1:0] CmdLoad     = 2'd0;
  localparam logic [1:0] CmdClassify = 2'd1;
  localparam logic [1:0] CmdEndPass  = 2'd2;

  localparam logic [1:0] CfgClusters  = 2'd0;
  localparam logic [1:0] CfgBands     = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;
  localparam logic [1:0] CfgMaxPasses = 2'd3;

  localparam logic KindLabel   = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] cluster_index;
    logic [7:0] band_0;
    logic [7:0] band_1;
    logic [7:0] band_2;
    logic [7:0] band_3;
    logic [7:0] band_4;
    logic [7:0] band_5;
    logic [7:0] band_6;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  label;
    logic [34:0] min_distance;
    logic [15:0] peak_shift;
    logic        converged;
    logic [9:0]  passes_done;
    logic        run_done;
  } out_item_t;

endpackage

// ===== rtl/kmc_divider.sv =====
// ----------------------------------------------------------------------------
// kmc_divider
// Radix-2 restoring divider: 40-bit dividend over an unsigned divisor.
// ----------------------------------------------------------------------------
module kmc_divider #(
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [39:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [39:0]   quotient_o
);
  logic [39:0] quo_q, quo_d;
  logic [DW:0] rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DW:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; div_d = div_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = dividend_i; rem_d = '0; div_d = divisor_i;
      cnt_d = 6'd40; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DW-1:0], quo_q[39]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; div_q <= div_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== rtl/kmeans_cluster_pass.sv =====
// ----------------------------------------------------------------------------
// kmeans_cluster_pass
// Lloyd k-means pass engine over multiband 8-bit pixels with Q8.8 centroids.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries commands: load a centroid,
// classify a pixel, or close a pass. Output channel out_valid_o/out_stall_i
// carries one result per classify or end-of-pass transaction.
// One transaction is taken at a time; in_stall_o stays high until the engine
// is idle again. The memories give one row per cycle through one read port.
// A load with a cluster index below MAX_CLUSTERS writes its centroid row and
// then runs a clearing pass over all rows of the sum and count memories.
// An unused command is dropped. A classify reads one centroid row per
// cluster in use; the next transaction can be taken as soon as its result
// is registered.
// An end-of-pass runs a 40-step serial divider per band of every non-empty
// cluster, registers its result, then runs the clearing pass.
// After reset the clearing pass runs first; no transaction is taken during it.
// A finished result sits in the output register; the engine takes the next
// transaction while it waits, but will not finish another result until the
// receiver has taken it. Centroids are undefined until loaded.
// ----------------------------------------------------------------------------
module kmeans_cluster_pass
  import kmc_pkg::*;
#(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_BANDS = 7,
  parameter int COUNT_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int KW = $clog2(MAX_CLUSTERS);
  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam logic [34:0] DistMax = {35{1'b1}};

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StCls   = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StUpd   = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  // rows: one row per cluster, all bands side by side
  logic [MAX_BANDS-1:0][15:0] cen_mem [MAX_CLUSTERS];
  logic [MAX_BANDS-1:0][31:0] sum_mem [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0]      cnt_mem [MAX_CLUSTERS];

  logic [3:0]  act_k_q;
  logic [2:0]  act_b_q;
  logic [15:0] thr_q;
  logic [9:0]  maxp_q;
  logic [9:0]  pass_q;

  logic [2:0]  st_q;
  logic [KW:0] k_q;           // issued row
  logic [KW-1:0] rk_q;        // row that the read data belongs to
  logic        rv_q;
  logic [KW-1:0] best_k_q;
  logic [34:0] best_q;
  logic        have_q;
  logic [BW-1:0] b_q;
  logic [15:0] chg_q;
  in_item_t    item_q;
  logic        pend_q;        // item taken, not yet processed
  logic        ovalid_q;
  out_item_t   odata_q;

  logic [MAX_BANDS-1:0][15:0] cen_rd_q;
  logic [MAX_BANDS-1:0][31:0] sum_rd_q;
  logic [COUNT_BITS-1:0]      cnt_rd_q;

  logic [4:0] nk;
  logic [3:0] nb;
  always_comb begin
    nk = (act_k_q == 4'd0) ? 5'd1 : {1'b0, act_k_q};
    if (32'(nk) > MAX_CLUSTERS) nk = 5'(MAX_CLUSTERS);
    nb = (act_b_q == 3'd0) ? 4'd1 : {1'b0, act_b_q};
    if (32'(nb) > MAX_BANDS) nb = 4'(MAX_BANDS);
  end

  logic [7:0] smp [MAX_BANDS];
  always_comb begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      case (b)
        0: smp[b] = item_q.band_0;
        1: smp[b] = item_q.band_1;
        2: smp[b] = item_q.band_2;
        3: smp[b] = item_q.band_3;
        4: smp[b] = item_q.band_4;
        5: smp[b] = item_q.band_5;
        6: smp[b] = item_q.band_6;
        default: smp[b] = 8'd0;
      endcase
    end
  end

  // distance of the current read row; squares registered first
  logic [MAX_BANDS-1:0][31:0] sq_q;
  logic [KW-1:0] sqk_q;
  logic          sqv_q;
  logic [31:0] sq_c [MAX_BANDS];
  always_comb begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      logic [16:0] df;
      df = {1'b0, smp[b], 8'd0} - {1'b0, cen_rd_q[b]};
      if (df[16]) df = -df;
      sq_c[b] = (32'(b) < 32'(nb)) ? (df[15:0] * df[15:0]) : 32'd0;
    end
  end
  logic [37:0] dsum;
  logic [34:0] row_dist;
  always_comb begin
    dsum = '0;
    for (int b = 0; b < MAX_BANDS; b++) dsum = dsum + 38'(sq_q[b]);
    row_dist = (dsum > 38'(DistMax)) ? DistMax : dsum[34:0];
  end

  // divider
  logic        dv_start, dv_done;
  logic [39:0] dv_quo;
  logic [BW-1:0] div_b;
  assign div_b = rv_q ? '0 : b_q + 1'b1;
  kmc_divider #(.DW(COUNT_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start),
    .dividend_i({sum_rd_q[div_b], 8'd0}), .divisor_i(cnt_rd_q),
    .done_o(dv_done), .quotient_o(dv_quo)
  );

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;
  assign in_stall_o = pend_q || (st_q != StIdle);
  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  logic [KW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_cen, wr_acc, clr_row;
  logic [KW-1:0] wr_addr;
  logic [MAX_BANDS-1:0][15:0] cen_wdata;
  logic [MAX_BANDS-1:0][31:0] sum_wdata;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [15:0] nv;
  always_comb begin
    nv = (dv_quo > 40'hFFFF) ? 16'hFFFF : dv_quo[15:0];
    sum_wdata = sum_rd_q;
    for (int b = 0; b < MAX_BANDS; b++) begin
      logic [32:0] s;
      s = {1'b0, sum_rd_q[b]} + ((32'(b) < 32'(nb)) ? 33'(smp[b]) : 33'd0);
      sum_wdata[b] = s[32] ? 32'hFFFF_FFFF : s[31:0];
    end
    cnt_wdata = (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + 1'b1;
  end

  logic [MAX_BANDS-1:0][15:0] upd_row_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cen_rd_q <= cen_mem[rd_addr];
      sum_rd_q <= sum_mem[rd_addr];
      cnt_rd_q <= cnt_mem[rd_addr];
    end
    if (wr_cen) cen_mem[wr_addr] <= cen_wdata;
    if (clr_row) begin
      sum_mem[wr_addr] <= '0;
      cnt_mem[wr_addr] <= '0;
    end else if (wr_acc) begin
      sum_mem[wr_addr] <= sum_wdata;
      cnt_mem[wr_addr] <= cnt_wdata;
    end
  end

  logic [2:0] st_d;
  logic [KW:0] k_d;
  always_comb begin
    st_d = st_q; k_d = k_q;
    rd_en = 1'b0; rd_addr = k_q[KW-1:0];
    wr_cen = 1'b0; wr_acc = 1'b0; clr_row = 1'b0;
    wr_addr = k_q[KW-1:0]; cen_wdata = upd_row_q;
    dv_start = 1'b0;
    case (st_q)
      StClear: begin
        clr_row = 1'b1;
        k_d = k_q + 1'b1;
        if (32'(k_q) == MAX_CLUSTERS - 1) begin
          st_d = StIdle; k_d = '0;
        end
      end
      StIdle: begin
        if (pend_q) begin
          k_d = '0;
          case (item_q.command)
            CmdLoad: begin
              for (int b = 0; b < MAX_BANDS; b++) cen_wdata[b] = {smp[b], 8'd0};
              wr_cen = 1'b1;
              wr_addr = KW'(item_q.cluster_index);
              if (32'(item_q.cluster_index) >= MAX_CLUSTERS) wr_cen = 1'b0;
              st_d = (32'(item_q.cluster_index) >= MAX_CLUSTERS) ? StIdle : StClear;
            end
            CmdClassify: st_d = StCls;
            CmdEndPass:  st_d = StUpd;
            default:     st_d = StIdle;
          endcase
        end
      end
      StCls: begin
        if (k_q < (KW+1)'(nk)) begin
          rd_en = 1'b1; k_d = k_q + 1'b1;
        end else if (!rv_q && !sqv_q) begin
          rd_en = 1'b1; rd_addr = best_k_q;
          st_d = StAcc;
        end
      end
      StAcc: begin
        // read data of best row arrives now
        if (!rv_q) begin
          wr_acc = 1'b1; wr_addr = best_k_q;
          st_d = StOut;
        end
      end
      StUpd: begin
        if (k_q >= (KW+1)'(nk)) begin
          st_d = StOut;
        end else begin
          rd_en = 1'b1;
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (rv_q) begin
          if (cnt_rd_q == '0) begin
            k_d = k_q + 1'b1; st_d = StUpd;
          end else dv_start = 1'b1;
        end else if (dv_done) begin
          if (32'(b_q) + 1 >= 32'(nb)) begin
            wr_cen = 1'b1; cen_wdata = upd_row_q; cen_wdata[b_q] = nv;
            k_d = k_q + 1'b1; st_d = StUpd;
          end else dv_start = 1'b1;
        end
      end
      StOut: begin
        if (out_free) begin
          st_d = (item_q.command == CmdClassify) ? StIdle : StClear;
          k_d = '0;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; k_q <= '0; rv_q <= 1'b0; sqv_q <= 1'b0;
      pend_q <= 1'b0; ovalid_q <= 1'b0; have_q <= 1'b0;
      act_k_q <= 4'd8; act_b_q <= 3'd7; thr_q <= 16'd1; maxp_q <= 10'd30;
      pass_q <= '0;
    end else begin
      st_q <= st_d; k_q <= k_d;
      rv_q <= rd_en && (st_q == StCls || st_q == StUpd);
      sqv_q <= rv_q && st_q == StCls;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgClusters:  act_k_q <= cfg_data_i[3:0];
          CfgBands:     act_b_q <= cfg_data_i[2:0];
          CfgThreshold: thr_q <= cfg_data_i;
          CfgMaxPasses: maxp_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (in_take) pend_q <= 1'b1;
      else if (st_q == StIdle && st_d != StIdle) pend_q <= 1'b0;
      else if (st_q == StIdle && pend_q) pend_q <= 1'b0;
      if (st_q == StIdle) have_q <= 1'b0;
      else if (sqv_q) have_q <= 1'b1;
      if (st_q == StIdle && pend_q && item_q.command == CmdLoad
          && 32'(item_q.cluster_index) < MAX_CLUSTERS) pass_q <= '0;
      if (st_q == StUpd && k_q >= (KW+1)'(nk) && pass_q != 10'd1023)
        pass_q <= pass_q + 1'b1;
      if (st_q == StOut && out_free) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // payload
  logic [9:0] pnext;
  always_comb pnext = pass_q;
  out_item_t onext;
  always_comb begin
    onext = '0;
    if (item_q.command == CmdClassify) begin
      onext.result_kind = KindLabel;
      onext.label = 3'(best_k_q);
      onext.min_distance = best_q;
    end else begin
      onext.result_kind = KindSummary;
      onext.peak_shift = chg_q;
      onext.converged = chg_q < thr_q;
      onext.passes_done = pnext;
      onext.run_done = (chg_q < thr_q) || (pnext >= maxp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= in_data_i;
    rk_q <= rd_addr;
    sqk_q <= rk_q;
    for (int b = 0; b < MAX_BANDS; b++) sq_q[b] <= sq_c[b];
    if (st_q == StIdle) begin
      best_k_q <= '0; best_q <= '0; chg_q <= '0;
    end else if (sqv_q && (!have_q || row_dist < best_q)) begin
      best_q <= row_dist; best_k_q <= sqk_q;
    end
    if (st_q == StDiv && rv_q) begin
      upd_row_q <= cen_rd_q; b_q <= '0;
    end else if (st_q == StDiv && dv_done) begin
      upd_row_q[b_q] <= nv;
      b_q <= b_q + 1'b1;
      if ((nv > cen_rd_q[b_q] ? nv - cen_rd_q[b_q] : cen_rd_q[b_q] - nv) > chg_q)
        chg_q <= nv > cen_rd_q[b_q] ? nv - cen_rd_q[b_q] : cen_rd_q[b_q] - nv;
    end
    if (st_q == StOut && out_free) odata_q <= onext;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;

`ifndef SYNTH
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StClear |-> !in_take) else $error("take during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q) else $error("result dropped");
  a_div_only_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> st_q == StDiv) else $error("divider started outside update");
`endif
endmodule
